>>> rtl/core/etm_pkg.sv
package etm_pkg;

    localparam int ROWS           = 3;
    localparam int LANES          = 3;
    localparam int CORDIC_STEPS   = 28;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int IN_DATA_W      = 192;
    localparam int OUT_DATA_W     = 104;
    localparam int PROD_W         = 49;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
    localparam logic [31:0]        SAT_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0]        SAT_MIN     = 32'h8000_0000;

    localparam logic MODE_MODEL  = 1'b0;
    localparam logic MODE_NORMAL = 1'b1;

    localparam logic [1:0] COL_TRANS       = 2'd3;
    localparam logic [1:0] LAST_COL_MODEL  = 2'd3;
    localparam logic [1:0] LAST_COL_NORMAL = 2'd2;

    // Arctangent of 2^-i in units of 2^32 per turn
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5
    };

    typedef logic signed [31:0]     q30_t;
    typedef logic [2:0][31:0]       trig_t;
    typedef logic [2:0][2:0][32:0]  rot_mat_t;

    typedef struct packed {
        logic             mode;
        logic [2:0][15:0] scale;
        logic [2:0][31:0] trans;
    } item_t;

    typedef struct packed {
        logic [1:0]           col;
        logic                 last;
        logic                 mode;
        logic                 is_trans;
        logic                 zsc;
        logic [2:0]           neg;
        logic [2:0]           rpos;
        logic [2:0]           rneg;
        logic [2:0][PROD_W-1:0] prod;
        logic [2:0][31:0]     trans;
    } col_side_t;

    // Extra numerator shift when the output has more than 22 fraction bits
    function automatic int dpos(input int frac);
        return (frac > 22) ? frac - 22 : 0;
    endfunction

    // Extra divisor shift when the output has fewer than 22 fraction bits
    function automatic int dneg(input int frac);
        return (frac < 22) ? 22 - frac : 0;
    endfunction

    // Q30 product rounded half up
    function automatic q30_t mulq(input q30_t a, input q30_t b);
        logic signed [63:0] p;
        p = a * b;
        p = p + (64'sd1 <<< 29);
        return p[61:30];
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) begin
            r = SAT_MAX;
        end else if (v < -64'sd2147483648) begin
            r = SAT_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/etm_cordic.sv
module etm_cordic #(
    parameter int ANGLE_BITS = etm_pkg::ANGLE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  logic [2:0][15:0]  in_angle,
    input  etm_pkg::item_t    in_item,
    output logic              out_vld,
    output etm_pkg::trig_t    out_cos,
    output etm_pkg::trig_t    out_sin,
    output etm_pkg::item_t    out_item
);

    localparam int N  = etm_pkg::CORDIC_STEPS;
    localparam int SH = 32 - ANGLE_BITS;

    logic [N+1:0]        vld_reg;
    etm_pkg::item_t      item_reg [N+2];
    logic [2:0]          flip_reg [N+1];
    logic signed [31:0]  x_reg [N+1][3];
    logic signed [31:0]  y_reg [N+1][3];
    logic signed [31:0]  z_reg [N+1][3];
    logic signed [31:0]  x_next [N+1][3];
    logic signed [31:0]  y_next [N+1][3];
    logic signed [31:0]  z_next [N+1][3];
    logic [2:0]          flip_next;
    etm_pkg::trig_t      cos_reg;
    etm_pkg::trig_t      sin_reg;
    etm_pkg::trig_t      cos_next;
    etm_pkg::trig_t      sin_next;

    // Fold into [-90, 90] degrees, then one rotation step per stage
    always_comb begin
        logic [31:0]        t;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] at;
        logic signed [31:0] xf;
        logic signed [31:0] yf;
        for (int l = 0; l < 3; l++) begin
            t = 32'({16'b0, in_angle[l]} << SH);
            flip_next[l] = t[31] ^ t[30];
            x_next[0][l] = etm_pkg::CORDIC_GAIN;
            y_next[0][l] = '0;
            z_next[0][l] = flip_next[l] ? $signed({~t[31], t[30:0]}) : $signed(t);
        end
        for (int s = 1; s <= N; s++) begin
            for (int l = 0; l < 3; l++) begin
                dx = y_reg[s-1][l] >>> (s - 1);
                dy = x_reg[s-1][l] >>> (s - 1);
                at = $signed(etm_pkg::ATAN_TURNS[s-1]);
                if (!z_reg[s-1][l][31]) begin
                    x_next[s][l] = x_reg[s-1][l] - dx;
                    y_next[s][l] = y_reg[s-1][l] + dy;
                    z_next[s][l] = z_reg[s-1][l] - at;
                end else begin
                    x_next[s][l] = x_reg[s-1][l] + dx;
                    y_next[s][l] = y_reg[s-1][l] - dy;
                    z_next[s][l] = z_reg[s-1][l] + at;
                end
            end
        end
        // Undo the fold and clamp to the unit range
        for (int l = 0; l < 3; l++) begin
            xf = flip_reg[N][l] ? -x_reg[N][l] : x_reg[N][l];
            yf = flip_reg[N][l] ? -y_reg[N][l] : y_reg[N][l];
            if (xf > etm_pkg::ONE_Q30) begin
                cos_next[l] = etm_pkg::ONE_Q30;
            end else if (xf < -etm_pkg::ONE_Q30) begin
                cos_next[l] = -etm_pkg::ONE_Q30;
            end else begin
                cos_next[l] = xf;
            end
            if (yf > etm_pkg::ONE_Q30) begin
                sin_next[l] = etm_pkg::ONE_Q30;
            end else if (yf < -etm_pkg::ONE_Q30) begin
                sin_next[l] = -etm_pkg::ONE_Q30;
            end else begin
                sin_next[l] = yf;
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N:0], in_vld};
        end
    end

    // Advance the data stages
    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[0] <= in_item;
            flip_reg[0] <= flip_next;
            for (int s = 1; s <= N + 1; s++) begin
                item_reg[s] <= item_reg[s-1];
            end
            for (int s = 1; s <= N; s++) begin
                flip_reg[s] <= flip_reg[s-1];
            end
            for (int s = 0; s <= N; s++) begin
                for (int l = 0; l < 3; l++) begin
                    x_reg[s][l] <= x_next[s][l];
                    y_reg[s][l] <= y_next[s][l];
                    z_reg[s][l] <= z_next[s][l];
                end
            end
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign out_vld  = vld_reg[N+1];
    assign out_cos  = cos_reg;
    assign out_sin  = sin_reg;
    assign out_item = item_reg[N+1];

endmodule

>>> rtl/core/etm_rot.sv
module etm_rot (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_vld,
    input  etm_pkg::trig_t     in_cos,
    input  etm_pkg::trig_t     in_sin,
    input  etm_pkg::item_t     in_item,
    output logic               out_vld,
    output etm_pkg::rot_mat_t  out_rot,
    output etm_pkg::item_t     out_item
);

    logic [2:0]         vld_reg;
    etm_pkg::item_t     item1_reg, item2_reg, item3_reg;
    etm_pkg::q30_t      c1, s1, c2, s2, c3, s3;
    etm_pkg::q30_t      c1c3_reg, s1s2_reg, c2s3_reg, c1s2_reg, c3s1_reg;
    etm_pkg::q30_t      c1s3_reg, c2c3_reg, s1s3_reg, c2s1_reg, c1c2_reg;
    etm_pkg::q30_t      s2a_reg, s3a_reg;
    etm_pkg::q30_t      t00_reg, t02_reg, t10_reg, t12_reg;
    etm_pkg::q30_t      c1c3b_reg, c2s3b_reg, c3s1b_reg, c1s3b_reg, c2c3b_reg;
    etm_pkg::q30_t      s1s3b_reg, c2s1b_reg, c1c2b_reg, s2b_reg;
    etm_pkg::rot_mat_t  rot_reg;

    // Lane 0 is the y angle, lane 1 the x angle, lane 2 the z angle
    assign c1 = $signed(in_cos[0]);
    assign s1 = $signed(in_sin[0]);
    assign c2 = $signed(in_cos[1]);
    assign s2 = $signed(in_sin[1]);
    assign c3 = $signed(in_cos[2]);
    assign s3 = $signed(in_sin[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Pairwise products
            c1c3_reg  <= etm_pkg::mulq(c1, c3);
            s1s2_reg  <= etm_pkg::mulq(s1, s2);
            c2s3_reg  <= etm_pkg::mulq(c2, s3);
            c1s2_reg  <= etm_pkg::mulq(c1, s2);
            c3s1_reg  <= etm_pkg::mulq(c3, s1);
            c1s3_reg  <= etm_pkg::mulq(c1, s3);
            c2c3_reg  <= etm_pkg::mulq(c2, c3);
            s1s3_reg  <= etm_pkg::mulq(s1, s3);
            c2s1_reg  <= etm_pkg::mulq(c2, s1);
            c1c2_reg  <= etm_pkg::mulq(c1, c2);
            s2a_reg   <= s2;
            s3a_reg   <= s3;
            item1_reg <= in_item;
            // Triple products, carry the rest
            t00_reg   <= etm_pkg::mulq(s1s2_reg, s3a_reg);
            t02_reg   <= etm_pkg::mulq(c1s2_reg, s3a_reg);
            t10_reg   <= etm_pkg::mulq(c3s1_reg, s2a_reg);
            t12_reg   <= etm_pkg::mulq(c1c3_reg, s2a_reg);
            c1c3b_reg <= c1c3_reg;
            c2s3b_reg <= c2s3_reg;
            c3s1b_reg <= c3s1_reg;
            c1s3b_reg <= c1s3_reg;
            c2c3b_reg <= c2c3_reg;
            s1s3b_reg <= s1s3_reg;
            c2s1b_reg <= c2s1_reg;
            c1c2b_reg <= c1c2_reg;
            s2b_reg   <= s2a_reg;
            item2_reg <= item1_reg;
            // Sums into the rotation matrix
            rot_reg[0][0] <= 33'(c1c3b_reg) + 33'(t00_reg);
            rot_reg[0][1] <= 33'(c2s3b_reg);
            rot_reg[0][2] <= 33'(t02_reg) - 33'(c3s1b_reg);
            rot_reg[1][0] <= 33'(t10_reg) - 33'(c1s3b_reg);
            rot_reg[1][1] <= 33'(c2c3b_reg);
            rot_reg[1][2] <= 33'(t12_reg) + 33'(s1s3b_reg);
            rot_reg[2][0] <= 33'(c2s1b_reg);
            rot_reg[2][1] <= -33'(s2b_reg);
            rot_reg[2][2] <= 33'(c1c2b_reg);
            item3_reg <= item2_reg;
        end
    end

    assign out_vld  = vld_reg[2];
    assign out_rot  = rot_reg;
    assign out_item = item3_reg;

endmodule

>>> rtl/core/etm_col.sv
module etm_col #(
    parameter int FRAC_BITS = etm_pkg::FRAC_BITS_DEF,
    parameter int NUM_W     = 33 + etm_pkg::dpos(etm_pkg::FRAC_BITS_DEF),
    parameter int DEN_W     = 16 + etm_pkg::dneg(etm_pkg::FRAC_BITS_DEF)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_vld,
    input  etm_pkg::rot_mat_t      in_rot,
    input  etm_pkg::item_t         in_item,
    output logic                   in_take,
    output logic                   out_vld,
    output logic [2:0][NUM_W-1:0]  out_num,
    output logic [DEN_W-1:0]       out_den,
    output etm_pkg::col_side_t     out_side
);

    localparam int DPOS = etm_pkg::dpos(FRAC_BITS);
    localparam int DNEG = etm_pkg::dneg(FRAC_BITS);

    logic                  busy_reg;
    logic [1:0]            col_reg;
    etm_pkg::rot_mat_t     rot_reg;
    etm_pkg::item_t        item_reg;
    logic                  vld_reg;
    logic [2:0][NUM_W-1:0] num_reg;
    logic [DEN_W-1:0]      den_reg;
    etm_pkg::col_side_t    side_reg;

    logic                  emit;
    logic                  is_last;
    logic [1:0]            kk;
    logic signed [15:0]    sc;
    logic [15:0]           sc_abs;
    logic [DEN_W-1:0]      den_next;
    logic [2:0][NUM_W-1:0] num_next;
    etm_pkg::col_side_t    side_next;

    assign emit    = busy_reg && en;
    assign is_last = (col_reg == ((item_reg.mode == etm_pkg::MODE_NORMAL) ?
                      etm_pkg::LAST_COL_NORMAL : etm_pkg::LAST_COL_MODEL));
    assign in_take = !busy_reg || (emit && is_last);

    // Step through the columns of the held matrix
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            col_reg  <= '0;
        end else if (in_take && in_vld) begin
            busy_reg <= 1'b1;
            col_reg  <= '0;
        end else if (emit && is_last) begin
            busy_reg <= 1'b0;
        end else if (emit) begin
            col_reg <= col_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take && in_vld) begin
            rot_reg  <= in_rot;
            item_reg <= in_item;
        end
    end

    // Prepare scale product and divider operands for the current column
    assign kk       = (col_reg == etm_pkg::COL_TRANS) ? 2'd0 : col_reg;
    assign sc       = $signed(item_reg.scale[kk]);
    assign sc_abs   = sc[15] ? 16'(-sc) : 16'(sc);
    assign den_next = DEN_W'(sc_abs) << DNEG;

    always_comb begin
        logic signed [32:0] r;
        logic [32:0]        r_abs;
        side_next.col      = col_reg;
        side_next.last     = is_last;
        side_next.mode     = item_reg.mode;
        side_next.is_trans = (col_reg == etm_pkg::COL_TRANS);
        side_next.zsc      = (col_reg != etm_pkg::COL_TRANS) &&
                             (item_reg.mode == etm_pkg::MODE_NORMAL) && (sc == 16'sd0);
        side_next.trans    = item_reg.trans;
        for (int l = 0; l < 3; l++) begin
            r = $signed(rot_reg[kk][l]);
            r_abs = r[32] ? 33'(-r) : 33'(r);
            side_next.prod[l] = r * sc;
            side_next.neg[l]  = r[32] ^ sc[15];
            side_next.rneg[l] = r[32];
            side_next.rpos[l] = !r[32] && (r != 33'sd0);
            num_next[l] = (NUM_W'(r_abs) << DPOS) + NUM_W'(den_next >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_num  = num_reg;
    assign out_den  = den_reg;
    assign out_side = side_reg;

endmodule

>>> rtl/core/etm_div.sv
module etm_div #(
    parameter int NUM_W = 33 + etm_pkg::dpos(etm_pkg::FRAC_BITS_DEF),
    parameter int DEN_W = 16 + etm_pkg::dneg(etm_pkg::FRAC_BITS_DEF)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_vld,
    input  logic [2:0][NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]       in_den,
    input  etm_pkg::col_side_t     in_side,
    output logic                   out_vld,
    output logic [2:0][NUM_W-1:0]  out_quo,
    output etm_pkg::col_side_t     out_side
);

    logic [NUM_W-1:0]      vld_reg;
    logic [DEN_W-1:0]      den_reg  [NUM_W];
    etm_pkg::col_side_t    side_reg [NUM_W];
    logic [2:0][NUM_W-1:0] num_reg  [NUM_W];
    logic [2:0][NUM_W-1:0] quo_reg  [NUM_W];
    logic [2:0][DEN_W-1:0] rem_reg  [NUM_W];
    logic [2:0][NUM_W-1:0] num_next [NUM_W];
    logic [2:0][NUM_W-1:0] quo_next [NUM_W];
    logic [2:0][DEN_W-1:0] rem_next [NUM_W];

    // One restoring quotient bit per stage, three rows side by side
    always_comb begin
        logic [DEN_W-1:0]      d;
        logic [2:0][NUM_W-1:0] n;
        logic [2:0][NUM_W-1:0] q;
        logic [2:0][DEN_W-1:0] rm;
        logic [DEN_W:0]        trial;
        for (int s = 0; s < NUM_W; s++) begin
            if (s == 0) begin
                d  = in_den;
                n  = in_num;
                q  = '0;
                rm = '0;
            end else begin
                d  = den_reg[s-1];
                n  = num_reg[s-1];
                q  = quo_reg[s-1];
                rm = rem_reg[s-1];
            end
            for (int l = 0; l < 3; l++) begin
                trial = {rm[l], n[l][NUM_W-1]};
                if (trial >= {1'b0, d}) begin
                    rem_next[s][l] = DEN_W'(trial - {1'b0, d});
                    quo_next[s][l] = {q[l][NUM_W-2:0], 1'b1};
                end else begin
                    rem_next[s][l] = trial[DEN_W-1:0];
                    quo_next[s][l] = {q[l][NUM_W-2:0], 1'b0};
                end
                num_next[s][l] = n[l] << 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NUM_W-2:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
            for (int s = 1; s < NUM_W; s++) begin
                den_reg[s]  <= den_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
            for (int s = 0; s < NUM_W; s++) begin
                num_reg[s] <= num_next[s];
                quo_reg[s] <= quo_next[s];
                rem_reg[s] <= rem_next[s];
            end
        end
    end

    assign out_vld  = vld_reg[NUM_W-1];
    assign out_quo  = quo_reg[NUM_W-1];
    assign out_side = side_reg[NUM_W-1];

endmodule

>>> rtl/core/etm_fmt.sv
module etm_fmt #(
    parameter int FRAC_BITS = etm_pkg::FRAC_BITS_DEF,
    parameter int NUM_W     = 33 + etm_pkg::dpos(etm_pkg::FRAC_BITS_DEF)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_vld,
    input  logic [2:0][NUM_W-1:0]             in_quo,
    input  etm_pkg::col_side_t                in_side,
    output logic                              out_vld,
    output logic [etm_pkg::OUT_DATA_W-1:0]    out_data,
    output logic                              out_last,
    output logic                              out_flag
);

    localparam int MSH = 38 - FRAC_BITS;
    localparam int TUP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int TDN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam logic signed [40:0] TRND = (41'sd1 <<< TDN) >>> 1;
    localparam logic signed [49:0] MRND = 50'sd1 <<< (MSH - 1);
    localparam logic [NUM_W-1:0]   Q_LIM = {{(NUM_W-32){1'b0}}, 32'h8000_0000};

    logic                           vld_reg;
    logic [etm_pkg::OUT_DATA_W-1:0] data_reg;
    logic                           last_reg;
    logic                           flag_reg;
    logic [2:0][31:0]               elem_next;

    // Pick translation, scaled entry, saturated entry or rounded quotient
    always_comb begin
        logic signed [40:0] tw;
        logic signed [49:0] mw;
        logic [NUM_W-1:0]   q;
        logic [NUM_W-1:0]   qn;
        for (int l = 0; l < 3; l++) begin
            tw = ((41'($signed(in_side.trans[l])) <<< TUP) + TRND) >>> TDN;
            mw = (50'($signed(in_side.prod[l])) + MRND) >>> MSH;
            q  = in_quo[l];
            qn = NUM_W'(0) - q;
            if (in_side.is_trans) begin
                elem_next[l] = etm_pkg::sat32(64'(tw));
            end else if (in_side.mode == etm_pkg::MODE_MODEL) begin
                elem_next[l] = etm_pkg::sat32(64'(mw));
            end else if (in_side.zsc) begin
                elem_next[l] = in_side.rpos[l] ? etm_pkg::SAT_MAX :
                               (in_side.rneg[l] ? etm_pkg::SAT_MIN : 32'h0);
            end else if (in_side.neg[l]) begin
                elem_next[l] = (q > Q_LIM) ? etm_pkg::SAT_MIN : qn[31:0];
            end else begin
                elem_next[l] = (q >= Q_LIM) ? etm_pkg::SAT_MAX : q[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= {6'b0, elem_next[2], elem_next[1], elem_next[0], in_side.col};
            last_reg <= in_side.last;
            flag_reg <= in_side.zsc;
        end
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;
    assign out_last = last_reg;
    assign out_flag = flag_reg;

endmodule

>>> rtl/core/euler_transform_matrix.sv
// Builds a Y-X-Z Euler scale/rotate/translate matrix per request. A model-mode
// request (tuser = 0) returns four column results (scaled rotation columns, then
// translation); a normal-mode request (tuser = 1) returns three rotation columns,
// each divided by its scale, with tuser set on a column whose scale was zero.
// tlast marks the final column. Requests are accepted every cycle while the
// pipeline has room; sustained throughput is set by the column sequencer, which
// feeds the single result channel one column per cycle while the output is not
// stalled, and takes the next matrix only as it emits the current last column.
// The path holds 30 register stages of sine/cosine, 3 of matrix products, 2 of
// column setup (matrix hold and operand prep), 33 + max(FRAC_BITS - 22, 0) of the
// bit-per-stage divider and 1 output register.
module euler_transform_matrix #(
    parameter int ANGLE_BITS = etm_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = etm_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // angle_x, angle_y, angle_z, scale_x, scale_y, scale_z, trans_x, trans_y, trans_z
    input  logic [etm_pkg::IN_DATA_W-1:0]     s_tdata,
    // mode
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // column_index, elem_row0, elem_row1, elem_row2, zero pad
    output logic [etm_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    // zero_scale
    output logic                              m_tuser
);

    localparam int NUM_W = 33 + etm_pkg::dpos(FRAC_BITS);
    localparam int DEN_W = 16 + etm_pkg::dneg(FRAC_BITS);

    logic                  front_en;
    logic                  back_en;
    logic [2:0][15:0]      angles;
    etm_pkg::item_t        item_in;
    logic                  cor_vld;
    etm_pkg::trig_t        cor_cos;
    etm_pkg::trig_t        cor_sin;
    etm_pkg::item_t        cor_item;
    logic                  rot_vld;
    etm_pkg::rot_mat_t     rot_mat;
    etm_pkg::item_t        rot_item;
    logic                  col_take;
    logic                  col_vld;
    logic [2:0][NUM_W-1:0] col_num;
    logic [DEN_W-1:0]      col_den;
    etm_pkg::col_side_t    col_side;
    logic                  div_vld;
    logic [2:0][NUM_W-1:0] div_quo;
    etm_pkg::col_side_t    div_side;

    // Unpack the request: lanes ordered y, x, z for the rotation products
    assign angles[0]     = s_tdata[31:16];
    assign angles[1]     = s_tdata[15:0];
    assign angles[2]     = s_tdata[47:32];
    assign item_in.mode  = s_tuser;
    assign item_in.scale = {s_tdata[95:80], s_tdata[79:64], s_tdata[63:48]};
    assign item_in.trans = {s_tdata[191:160], s_tdata[159:128], s_tdata[127:96]};

    // Hold the back end while the result is not taken; hold the front end
    // while the column sequencer is busy
    assign back_en  = !m_tvalid || m_tready;
    assign front_en = !rot_vld || col_take;
    assign s_tready = front_en;

    etm_cordic #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (front_en),
        .in_vld   (s_tvalid),
        .in_angle (angles),
        .in_item  (item_in),
        .out_vld  (cor_vld),
        .out_cos  (cor_cos),
        .out_sin  (cor_sin),
        .out_item (cor_item)
    );

    etm_rot u_rot (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (front_en),
        .in_vld   (cor_vld),
        .in_cos   (cor_cos),
        .in_sin   (cor_sin),
        .in_item  (cor_item),
        .out_vld  (rot_vld),
        .out_rot  (rot_mat),
        .out_item (rot_item)
    );

    etm_col #(
        .FRAC_BITS (FRAC_BITS),
        .NUM_W     (NUM_W),
        .DEN_W     (DEN_W)
    ) u_col (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (back_en),
        .in_vld   (rot_vld),
        .in_rot   (rot_mat),
        .in_item  (rot_item),
        .in_take  (col_take),
        .out_vld  (col_vld),
        .out_num  (col_num),
        .out_den  (col_den),
        .out_side (col_side)
    );

    etm_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (back_en),
        .in_vld   (col_vld),
        .in_num   (col_num),
        .in_den   (col_den),
        .in_side  (col_side),
        .out_vld  (div_vld),
        .out_quo  (div_quo),
        .out_side (div_side)
    );

    etm_fmt #(
        .FRAC_BITS (FRAC_BITS),
        .NUM_W     (NUM_W)
    ) u_fmt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (back_en),
        .in_vld   (div_vld),
        .in_quo   (div_quo),
        .in_side  (div_side),
        .out_vld  (m_tvalid),
        .out_data (m_tdata),
        .out_last (m_tlast),
        .out_flag (m_tuser)
    );

endmodule
